@@ sv/ffha_pkg.sv @@
// Package for the first-fit heap allocator: defaults, constants and the controller states.
package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ALIGN_BYTES      = 8;
    localparam int ALIGN_SHIFT      = 3;
    localparam int REQ_W            = 12;
    localparam int OFF_W            = 12;
    localparam int GRANT_W          = 10;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_CHK,
        ST_A_SPLIT_W,
        ST_A_CUR_W,
        ST_R_P_RD,
        ST_R_P_WR,
        ST_R_N_RD,
        ST_R_N_WR,
        ST_F_CHK,
        ST_F_B_W,
        ST_F_H_RD,
        ST_F_H_WR,
        ST_F_NX,
        ST_F_NX_CHK,
        ST_F_B_RD,
        ST_F_B_SZ_W,
        ST_F_PP,
        ST_F_PP_CHK,
        ST_F_B2_CHK,
        ST_F_PP_RD,
        ST_F_PP_W,
        ST_DONE
    } state_t;

endpackage

@@ sv/ffha_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator with free-list coalescing.
//
//  channel   | direction | beat contents
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tuser: func; tdata: req_bytes, block_offset
//  m_axis    | out       | tuser: ok; tdata: granted_offset (zero padded)
//
// Steps: an allocate walks the free list from the head, reading one block at a
// time, and on a fit writes the split remainder and the block header and relinks
// the neighbours; a free walks the blocks physically from granule 0 up to it,
// then pushes it at the list head and merges it with its free physical neighbours.
// Reset: one cycle after reset is spent writing the initial free block header.
// Stalls: a finished result waits in the output register while the next
// request is already taken; only the final load step waits for it to drain.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] req_bytes, [23:12] block_offset
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] granted_offset, [15:12] zero
    output logic        m_axis_tuser    // [0] ok
);

    // Heap geometry in granules; a link equal to GRAN is the empty link.
    localparam int GRAN  = HEAP_BYTES / ffha_pkg::ALIGN_BYTES;
    localparam int HDR_G = HEADER_BYTES / ffha_pkg::ALIGN_BYTES;
    localparam int AW    = $clog2(GRAN);
    localparam int LW    = $clog2(GRAN + 1);
    localparam int SW    = $clog2(GRAN);
    localparam int MW    = SW + 1 + 2 * LW;
    localparam int CW    = ((LW > 10) ? LW : 10) + 2;
    localparam int AP    = SW;
    localparam int PP    = SW + 1;
    localparam int NP    = SW + 1 + LW;

    localparam logic [LW-1:0] NIL      = LW'(GRAN);
    localparam logic [CW-1:0] GRAN_C   = CW'(GRAN);
    localparam logic [CW-1:0] HDR_C    = CW'(HDR_G);
    localparam logic [SW-1:0] INIT_SZ  = SW'(GRAN - HDR_G);
    localparam logic [CW-1:0] HDRB_C   = CW'(HEADER_BYTES);

    ffha_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [LW-1:0] cur_reg, cur_next, pp_reg, pp_next, b_reg, b_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] rp_reg, rp_next, rn_reg, rn_next, rx_reg, rx_next, ry_reg, ry_next;
    logic [9:0]    ag_reg, ag_next;
    logic [MW-1:0] hdr_reg, hdr_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic          split_reg, split_next;
    logic          res_ok_reg, res_ok_next;
    logic [11:0]   res_off_reg, res_off_next;
    logic          mv_reg, mv_next;
    logic          mok_reg, mok_next;
    logic [11:0]   moff_reg, moff_next;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [MW-1:0] wdata, rdata;

    // Fields of the header just read (r_) and of the saved header (h_).
    logic [SW-1:0] r_size;
    logic          r_alloc;
    logic [LW-1:0] r_prev, r_next;
    logic [SW-1:0] h_size;
    logic [LW-1:0] h_prev, h_next;

    logic [CW-1:0] ag_c, size_c, cur_c, nb_c, nc_c, nx_c, bg_c;
    logic [11:0]   start;
    logic          accept;

    assign r_size  = rdata[SW-1:0];
    assign r_alloc = rdata[AP];
    assign r_prev  = rdata[PP +: LW];
    assign r_next  = rdata[NP +: LW];
    assign h_size  = hdr_reg[SW-1:0];
    assign h_prev  = hdr_reg[PP +: LW];
    assign h_next  = hdr_reg[NP +: LW];

    assign ag_c   = CW'(ag_reg);
    assign size_c = CW'(r_size);
    assign cur_c  = CW'(cur_reg);
    assign nb_c   = cur_c + ag_c + HDR_C;
    assign nc_c   = cur_c + HDR_C + size_c;
    assign nx_c   = CW'(b_reg) + HDR_C + CW'(h_size);
    assign start  = s_axis_tdata[23:12] - 12'(HEADER_BYTES);
    assign bg_c   = CW'(start[11:ffha_pkg::ALIGN_SHIFT]);

    assign s_axis_tready = (state_reg == ffha_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tuser  = mok_reg;
    assign m_axis_tdata  = {4'b0000, moff_reg};

    ffha_ram #(
        .WIDTH (MW),
        .DEPTH (GRAN)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::ST_INIT;
            ret_reg   <= ffha_pkg::ST_DONE;
            head_reg  <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            head_reg  <= head_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        pp_reg      <= pp_next;
        b_reg       <= b_next;
        rp_reg      <= rp_next;
        rn_reg      <= rn_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        ag_reg      <= ag_next;
        hdr_reg     <= hdr_next;
        sz_reg      <= sz_next;
        split_reg   <= split_next;
        res_ok_reg  <= res_ok_next;
        res_off_reg <= res_off_next;
        mok_reg     <= mok_next;
        moff_reg    <= moff_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        head_next    = head_reg;
        mv_next      = mv_reg;
        cur_next     = cur_reg;
        pp_next      = pp_reg;
        b_next       = b_reg;
        rp_next      = rp_reg;
        rn_next      = rn_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        ag_next      = ag_reg;
        hdr_next     = hdr_reg;
        sz_next      = sz_reg;
        split_next   = split_reg;
        res_ok_next  = res_ok_reg;
        res_off_next = res_off_reg;
        mok_next     = mok_reg;
        moff_next    = moff_reg;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        raddr        = '0;

        if (mv_reg && m_axis_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ffha_pkg::ST_INIT:
            begin
                // The whole heap starts as one free block at granule 0.
                we         = 1'b1;
                waddr      = '0;
                wdata      = {NIL, NIL, 1'b0, INIT_SZ};
                state_next = ffha_pkg::ST_IDLE;
            end

            ffha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_ok_next  = 1'b0;
                    res_off_next = '0;
                    state_next   = ffha_pkg::ST_DONE;
                    if (s_axis_tuser == ffha_pkg::FUNC_ALLOC)
                    begin
                        ag_next = 10'((13'(s_axis_tdata[11:0]) + 13'd7) >> ffha_pkg::ALIGN_SHIFT);
                        if (head_reg != NIL)
                        begin
                            cur_next   = head_reg;
                            re         = 1'b1;
                            raddr      = head_reg[AW-1:0];
                            state_next = ffha_pkg::ST_A_CHK;
                        end
                    end
                    else if (s_axis_tdata[23:12] >= 12'(HEADER_BYTES) &&
                             start[ffha_pkg::ALIGN_SHIFT-1:0] == '0 && bg_c < GRAN_C)
                    begin
                        // Walk the blocks physically from granule 0.
                        b_next     = bg_c[LW-1:0];
                        cur_next   = '0;
                        pp_next    = NIL;
                        re         = 1'b1;
                        raddr      = '0;
                        state_next = ffha_pkg::ST_F_CHK;
                    end
                end
            end

            ffha_pkg::ST_A_CHK:
            begin
                if (!r_alloc && size_c >= ag_c)
                begin
                    hdr_next = rdata;
                    if (size_c > ag_c + HDR_C)
                    begin
                        if (nb_c >= GRAN_C)
                        begin
                            state_next = ffha_pkg::ST_DONE;
                        end
                        else
                        begin
                            split_next = 1'b1;
                            rp_next    = r_prev;
                            rn_next    = r_next;
                            rx_next    = nb_c[LW-1:0];
                            ry_next    = nb_c[LW-1:0];
                            state_next = ffha_pkg::ST_A_SPLIT_W;
                        end
                    end
                    else
                    begin
                        split_next = 1'b0;
                        rp_next    = r_prev;
                        rn_next    = r_next;
                        rx_next    = r_next;
                        ry_next    = r_prev;
                        state_next = ffha_pkg::ST_A_CUR_W;
                    end
                end
                else if (r_next == NIL)
                begin
                    state_next = ffha_pkg::ST_DONE;
                end
                else
                begin
                    cur_next = r_next;
                    re       = 1'b1;
                    raddr    = r_next[AW-1:0];
                end
            end

            ffha_pkg::ST_A_SPLIT_W:
            begin
                // The remainder takes the list place of the split block.
                we         = 1'b1;
                waddr      = rx_reg[AW-1:0];
                wdata      = {h_next, h_prev, 1'b0, SW'(CW'(h_size) - ag_c - HDR_C)};
                state_next = ffha_pkg::ST_A_CUR_W;
            end

            ffha_pkg::ST_A_CUR_W:
            begin
                we           = 1'b1;
                waddr        = cur_reg[AW-1:0];
                wdata        = {h_next, h_prev, 1'b1, split_reg ? SW'(ag_reg) : h_size};
                res_ok_next  = 1'b1;
                res_off_next = 12'((cur_c << ffha_pkg::ALIGN_SHIFT) + HDRB_C);
                ret_next     = ffha_pkg::ST_DONE;
                state_next   = ffha_pkg::ST_R_P_RD;
            end

            // Relink: prev.next (or the list head) gets rx, next.prev gets ry.
            ffha_pkg::ST_R_P_RD:
            begin
                if (rp_reg != NIL)
                begin
                    re         = 1'b1;
                    raddr      = rp_reg[AW-1:0];
                    state_next = ffha_pkg::ST_R_P_WR;
                end
                else
                begin
                    head_next  = rx_reg;
                    state_next = ffha_pkg::ST_R_N_RD;
                end
            end

            ffha_pkg::ST_R_P_WR:
            begin
                we         = 1'b1;
                waddr      = rp_reg[AW-1:0];
                wdata      = rdata;
                wdata[NP +: LW] = rx_reg;
                state_next = ffha_pkg::ST_R_N_RD;
            end

            ffha_pkg::ST_R_N_RD:
            begin
                if (rn_reg != NIL)
                begin
                    re         = 1'b1;
                    raddr      = rn_reg[AW-1:0];
                    state_next = ffha_pkg::ST_R_N_WR;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end

            ffha_pkg::ST_R_N_WR:
            begin
                we         = 1'b1;
                waddr      = rn_reg[AW-1:0];
                wdata      = rdata;
                wdata[PP +: LW] = ry_reg;
                state_next = ret_reg;
            end

            ffha_pkg::ST_F_CHK:
            begin
                if (cur_reg < b_reg)
                begin
                    if (nc_c < GRAN_C)
                    begin
                        pp_next  = cur_reg;
                        cur_next = nc_c[LW-1:0];
                        re       = 1'b1;
                        raddr    = nc_c[AW-1:0];
                    end
                    else
                    begin
                        state_next = ffha_pkg::ST_DONE;
                    end
                end
                else if (cur_reg == b_reg && r_alloc)
                begin
                    hdr_next   = rdata;
                    state_next = ffha_pkg::ST_F_B_W;
                end
                else
                begin
                    state_next = ffha_pkg::ST_DONE;
                end
            end

            ffha_pkg::ST_F_B_W:
            begin
                // Push the freed block at the list head.
                we    = 1'b1;
                waddr = b_reg[AW-1:0];
                wdata = {head_reg, NIL, 1'b0, h_size};
                if (head_reg != NIL)
                begin
                    state_next = ffha_pkg::ST_F_H_RD;
                end
                else
                begin
                    head_next  = b_reg;
                    state_next = ffha_pkg::ST_F_NX;
                end
            end

            ffha_pkg::ST_F_H_RD:
            begin
                re         = 1'b1;
                raddr      = head_reg[AW-1:0];
                state_next = ffha_pkg::ST_F_H_WR;
            end

            ffha_pkg::ST_F_H_WR:
            begin
                we         = 1'b1;
                waddr      = head_reg[AW-1:0];
                wdata      = rdata;
                wdata[PP +: LW] = b_reg;
                head_next  = b_reg;
                state_next = ffha_pkg::ST_F_NX;
            end

            ffha_pkg::ST_F_NX:
            begin
                if (nx_c < GRAN_C)
                begin
                    re         = 1'b1;
                    raddr      = nx_c[AW-1:0];
                    state_next = ffha_pkg::ST_F_NX_CHK;
                end
                else
                begin
                    state_next = ffha_pkg::ST_F_PP;
                end
            end

            ffha_pkg::ST_F_NX_CHK:
            begin
                if (!r_alloc)
                begin
                    rp_next    = r_prev;
                    rn_next    = r_next;
                    rx_next    = r_next;
                    ry_next    = r_prev;
                    sz_next    = r_size;
                    ret_next   = ffha_pkg::ST_F_B_RD;
                    state_next = ffha_pkg::ST_R_P_RD;
                end
                else
                begin
                    state_next = ffha_pkg::ST_F_PP;
                end
            end

            ffha_pkg::ST_F_B_RD:
            begin
                // The relink may have changed the links of the freed block.
                re         = 1'b1;
                raddr      = b_reg[AW-1:0];
                state_next = ffha_pkg::ST_F_B_SZ_W;
            end

            ffha_pkg::ST_F_B_SZ_W:
            begin
                we         = 1'b1;
                waddr      = b_reg[AW-1:0];
                wdata      = rdata;
                wdata[SW-1:0] = SW'(size_c + HDR_C + CW'(sz_reg));
                state_next = ffha_pkg::ST_F_PP;
            end

            ffha_pkg::ST_F_PP:
            begin
                if (pp_reg != NIL)
                begin
                    re         = 1'b1;
                    raddr      = pp_reg[AW-1:0];
                    state_next = ffha_pkg::ST_F_PP_CHK;
                end
                else
                begin
                    res_ok_next = 1'b1;
                    state_next  = ffha_pkg::ST_DONE;
                end
            end

            ffha_pkg::ST_F_PP_CHK:
            begin
                if (!r_alloc)
                begin
                    re         = 1'b1;
                    raddr      = b_reg[AW-1:0];
                    state_next = ffha_pkg::ST_F_B2_CHK;
                end
                else
                begin
                    res_ok_next = 1'b1;
                    state_next  = ffha_pkg::ST_DONE;
                end
            end

            ffha_pkg::ST_F_B2_CHK:
            begin
                // Unlink the freed block; it folds into the previous one.
                rp_next    = r_prev;
                rn_next    = r_next;
                rx_next    = r_next;
                ry_next    = r_prev;
                sz_next    = r_size;
                ret_next   = ffha_pkg::ST_F_PP_RD;
                state_next = ffha_pkg::ST_R_P_RD;
            end

            ffha_pkg::ST_F_PP_RD:
            begin
                re         = 1'b1;
                raddr      = pp_reg[AW-1:0];
                state_next = ffha_pkg::ST_F_PP_W;
            end

            ffha_pkg::ST_F_PP_W:
            begin
                we          = 1'b1;
                waddr       = pp_reg[AW-1:0];
                wdata       = rdata;
                wdata[SW-1:0] = SW'(size_c + HDR_C + CW'(sz_reg));
                res_ok_next = 1'b1;
                state_next  = ffha_pkg::ST_DONE;
            end

            ffha_pkg::ST_DONE:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    mv_next    = 1'b1;
                    mok_next   = res_ok_reg;
                    moff_next  = res_off_reg;
                    state_next = ffha_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ffha_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
